// ===== hw/rtl/stereo_sine_oscillator_macros.svh =====
// Assertion helpers shared by the oscillator modules.
// Each expects signals named clk and rst in the module that uses it.
`ifndef STEREO_SINE_OSCILLATOR_MACROS_SVH
`define STEREO_SINE_OSCILLATOR_MACROS_SVH

`ifndef SYNTH
`define SSO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SSO_ASSERT_SAME(lbl, ante, cons)
`define SSO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/sso_pkg.sv =====
package sso_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int INC_BITS  = 32;
  localparam int AMP_BITS  = 15;
  localparam int MAG_BITS  = 15;
  localparam int PROD_BITS = AMP_BITS + MAG_BITS;
  localparam int SCALE_SHIFT = 31 - SAMPLE_BITS;

  localparam int TABLE_N     = 1 << TABLE_ADDR_BITS;
  localparam int TABLE_DEPTH = TABLE_N + 1;
  localparam int ROM_ADDR_BITS = $clog2(TABLE_DEPTH);

  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [INC_BITS-1:0] LEFT_INC_RESET  = 32'd42852282;
  localparam logic [INC_BITS-1:0] RIGHT_INC_RESET = 32'd34281826;
  localparam logic [AMP_BITS-1:0] AMP_RESET       = 15'd6554;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEFT_INC  = 2'd0,
    CFG_RIGHT_INC = 2'd1,
    CFG_AMPLITUDE = 2'd2
  } cfg_index_t;

  typedef logic [PHASE_BITS-1:0]    phase_t;
  typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;
  typedef logic [MAG_BITS-1:0]      mag_t;
  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [PROD_BITS-1:0]     prod_t;

  // One frame request after classification: table address and sign per channel.
  typedef struct packed {
    rom_addr_t left_addr;
    logic      left_neg;
    rom_addr_t right_addr;
    logic      right_neg;
  } frame_req_t;

  typedef mag_t sine_rom_t [TABLE_DEPTH];

  // Q30 constants for the Taylor sum.
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  function automatic mag_t sine_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (PI_HALF_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return mag_t'(v);
  endfunction

  function automatic sine_rom_t build_sine_table();
    sine_rom_t t;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/sso_front.sv =====
`include "stereo_sine_oscillator_macros.svh"

module sso_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic                               tick,
  input  logic [sso_pkg::INC_BITS-1:0]       left_inc,
  input  logic [sso_pkg::INC_BITS-1:0]       right_inc,
  output logic                               push,
  output sso_pkg::frame_req_t                push_req,
  input  logic                               queue_ready
);

  sso_pkg::phase_t left_acc;
  sso_pkg::phase_t right_acc;
  logic            fire;

  assign req_ready = queue_ready;
  assign fire      = req_valid && queue_ready;
  assign push      = fire;

  // quadrant in the top two bits; odd quadrants read the table mirrored
  function automatic sso_pkg::rom_addr_t quad_addr(sso_pkg::phase_t ph);
    logic                                    q0;
    logic [sso_pkg::TABLE_ADDR_BITS-1:0]     idx;
    q0  = ph[sso_pkg::PHASE_BITS-2];
    idx = ph[sso_pkg::PHASE_BITS-3 -: sso_pkg::TABLE_ADDR_BITS];
    if (q0) begin
      return sso_pkg::rom_addr_t'(sso_pkg::TABLE_N) - sso_pkg::rom_addr_t'(idx);
    end else begin
      return sso_pkg::rom_addr_t'(idx);
    end
  endfunction

  always_comb begin
    push_req.left_addr  = quad_addr(left_acc);
    push_req.left_neg   = left_acc[sso_pkg::PHASE_BITS-1];
    push_req.right_addr = quad_addr(right_acc);
    push_req.right_neg  = right_acc[sso_pkg::PHASE_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_acc  <= '0;
      right_acc <= '0;
    end else if (fire && tick) begin
      left_acc  <= left_acc + sso_pkg::phase_t'(left_inc);
      right_acc <= right_acc + sso_pkg::phase_t'(right_inc);
    end
  end

  `SSO_ASSERT_NEXT(a_hold_phase, fire && !tick, $stable(left_acc) && $stable(right_acc))
  `SSO_ASSERT_NEXT(a_step_phase, fire && tick,
      left_acc == $past(left_acc + sso_pkg::phase_t'(left_inc)))

endmodule

// ===== hw/rtl/sso_queue.sv =====
`include "stereo_sine_oscillator_macros.svh"

module sso_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sso_pkg::frame_req_t push_req,
  output logic                push_ready,
  output logic                pop_valid,
  input  logic                pop,
  output sso_pkg::frame_req_t pop_req
);

  sso_pkg::frame_req_t                 entries [sso_pkg::QUEUE_DEPTH];
  logic [sso_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [sso_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [sso_pkg::QUEUE_CNT_BITS-1:0]  count;
  logic                                do_push;
  logic                                do_pop;

  localparam logic [sso_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      sso_pkg::QUEUE_PTR_BITS'(sso_pkg::QUEUE_DEPTH - 1);
  localparam logic [sso_pkg::QUEUE_CNT_BITS-1:0] FULL_CNT =
      sso_pkg::QUEUE_CNT_BITS'(sso_pkg::QUEUE_DEPTH);

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SSO_ASSERT_SAME(a_count_range, 1'b1, count <= FULL_CNT)

endmodule

// ===== hw/rtl/sso_back.sv =====
`include "stereo_sine_oscillator_macros.svh"

module sso_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_pop,
  input  sso_pkg::frame_req_t          req,
  input  logic [sso_pkg::AMP_BITS-1:0] amplitude,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sso_pkg::sample_t             left_sample,
  output sso_pkg::sample_t             right_sample
);

  localparam sso_pkg::sine_rom_t SINE_ROM = sso_pkg::build_sine_table();

  logic          s1_valid;
  sso_pkg::mag_t left_mag;
  sso_pkg::mag_t right_mag;
  logic          left_neg;
  logic          right_neg;
  logic          advance;
  logic          load;

  assign advance = !out_valid || out_ready;
  assign load    = !s1_valid || advance;
  assign req_pop = req_valid && load;

  // table read, registered
  always_ff @(posedge clk) begin
    if (load) begin
      left_mag  <= SINE_ROM[req.left_addr];
      right_mag <= SINE_ROM[req.right_addr];
      left_neg  <= req.left_neg;
      right_neg <= req.right_neg;
    end
  end

  // amplitude times signed sine, floor shift
  function automatic sso_pkg::sample_t scale(logic [sso_pkg::AMP_BITS-1:0] amp,
                                             sso_pkg::mag_t mag, logic neg);
    sso_pkg::prod_t     prod;
    logic signed [31:0] sp;
    logic signed [31:0] sh;
    prod = amp * mag;
    sp   = neg ? -$signed(32'(prod)) : $signed(32'(prod));
    sh   = sp >>> sso_pkg::SCALE_SHIFT;
    return sh[sso_pkg::SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      left_sample  <= scale(amplitude, left_mag, left_neg);
      right_sample <= scale(amplitude, right_mag, right_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= req_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  `SSO_ASSERT_NEXT(a_pop_loads, req_pop, s1_valid)

endmodule

// ===== hw/rtl/stereo_sine_oscillator.sv =====
// Stereo sine oscillator. Each request on the s_ side (tick in bit 0) yields one
// stereo frame on the m_ side: amplitude times the sine of the left and right
// phase accumulators, taken before the phases advance; tick = 1 then adds each
// channel's increment, tick = 0 leaves them. Sine comes from a 1025-entry
// quarter-wave table built at elaboration. One frame per clock sustained while
// m_tready stays high; a taken request passes through the queue stage, the
// registered two-port table read and the output multiply register. A four
// deep queue decouples the request side from the output. Configuration:
// index 0 left increment, 1 right increment, 2 amplitude (Q0.15); write only
// while idle. Other indexes are ignored.
module stereo_sine_oscillator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sso_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [0] tick, rest zero
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sso_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // {right_sample, left_sample}
  input  logic                                 cfg_we,
  input  logic [sso_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sso_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [sso_pkg::INC_BITS-1:0] left_inc;
  logic [sso_pkg::INC_BITS-1:0] right_inc;
  logic [sso_pkg::AMP_BITS-1:0] amplitude;

  logic                push;
  sso_pkg::frame_req_t push_req;
  logic                queue_ready;
  logic                pop_valid;
  logic                pop;
  sso_pkg::frame_req_t pop_req;
  sso_pkg::sample_t    left_sample;
  sso_pkg::sample_t    right_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_inc  <= sso_pkg::LEFT_INC_RESET;
      right_inc <= sso_pkg::RIGHT_INC_RESET;
      amplitude <= sso_pkg::AMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sso_pkg::CFG_LEFT_INC:  left_inc  <= cfg_data[sso_pkg::INC_BITS-1:0];
        sso_pkg::CFG_RIGHT_INC: right_inc <= cfg_data[sso_pkg::INC_BITS-1:0];
        sso_pkg::CFG_AMPLITUDE: amplitude <= cfg_data[sso_pkg::AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  sso_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .tick        (s_tdata[0]),
    .left_inc    (left_inc),
    .right_inc   (right_inc),
    .push        (push),
    .push_req    (push_req),
    .queue_ready (queue_ready)
  );

  sso_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .push_ready (queue_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req)
  );

  sso_back u_back (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (pop_valid),
    .req_pop      (pop),
    .req          (pop_req),
    .amplitude    (amplitude),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .left_sample  (left_sample),
    .right_sample (right_sample)
  );

  assign m_tdata = sso_pkg::OUT_DATA_BITS'({right_sample, left_sample});

endmodule
